// ===== src/pmecs_pkg.sv =====
// Shared types, constants and codes for the PME charge spreading block.
// No dependencies; imported by every module of the block.
package pmecs_pkg;

  localparam int SPLINE_ORDER_DEF = 4;
  localparam int MAX_GRID_DIM_DEF = 32;

  localparam int POS_W    = 32;
  localparam int CHG_W    = 32;
  localparam int INV_W    = 32;
  localparam int GSZ_W    = 6;
  localparam int IDX_W    = 15;
  localparam int CELL_W   = 48;
  localparam int FRAC_W   = 30;
  localparam int WT_W     = 31;
  localparam int ADD_W    = 34;
  localparam int GAW      = 18;
  localparam int BASE_OFF = 23;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  localparam int CHARGE_SKIP = 27;

  localparam int DIV_NUM_W  = 40;
  localparam int DIV_DEN_W  = 7;
  localparam int DIV_DIGIT  = 8;

  typedef enum logic [2:0] {
    REG_GRID_X = 3'd0,
    REG_GRID_Y = 3'd1,
    REG_GRID_Z = 3'd2,
    REG_INV_X  = 3'd3,
    REG_INV_Y  = 3'd4,
    REG_INV_Z  = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_SPL_MUL,
    ST_SPL_SCALE,
    ST_SPL_WRAP,
    ST_SPL_WAIT,
    ST_BS_MUL,
    ST_BS_SUM,
    ST_BS_WAIT,
    ST_CELL_A,
    ST_CELL_B,
    ST_CELL_C,
    ST_CELL_D
  } ctrl_state_e;

  typedef struct packed {
    logic                    rd_en;
    logic [GAW-1:0]          rd_addr;
    logic                    wr_en;
    logic                    wr_acc;
    logic [GAW-1:0]          wr_addr;
    logic signed [ADD_W-1:0] add_val;
  } grid_req_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== src/pmecs_div.sv =====
// Digit-serial unsigned divider, one byte of quotient per cycle.
// Depends on pmecs_pkg for widths and request/response structs.
module pmecs_div import pmecs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int STEPS = DIV_NUM_W / DIV_DIGIT;
  localparam int CNT_W = $clog2(STEPS);
  localparam int RW    = DIV_DEN_W + 1;

  logic                 busy_q, done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [RW-1:0]        rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q;

  always_comb begin
    logic [RW-1:0]        r;
    logic [DIV_NUM_W-1:0] n;
    r = rem_q;
    n = num_q;
    for (int i = 0; i < DIV_DIGIT; i++) begin
      r = {r[RW-2:0], n[DIV_NUM_W-1]};
      n = {n[DIV_NUM_W-2:0], 1'b0};
      if (r >= {1'b0, den_q}) begin
        r = r - {1'b0, den_q};
        n[0] = 1'b1;
      end
    end
    rem_d = r;
    num_d = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = num_q;
  assign rsp_o.rem  = rem_q[DIV_DEN_W-1:0];

endmodule

// ===== src/pmecs_grid.sv =====
// Charge grid memory with saturating accumulate, clear-on-read and reset sweep.
// Depends on pmecs_pkg for the request struct and widths.
module pmecs_grid import pmecs_pkg::*; #(
  parameter int MAX_GRID_DIM = MAX_GRID_DIM_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  grid_req_t                req_i,
  output logic signed [CELL_W-1:0] rdata_o,
  output logic                     clearing_o
);

  localparam int DEPTH  = MAX_GRID_DIM * MAX_GRID_DIM * MAX_GRID_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic signed [CELL_W:0] SAT_MAX = {2'b00, {(CELL_W-1){1'b1}}};
  localparam logic signed [CELL_W:0] SAT_MIN = {2'b11, {(CELL_W-1){1'b0}}};

  logic signed [CELL_W-1:0] mem [DEPTH];
  logic signed [CELL_W-1:0] rdata_q;
  logic                     clr_q;
  logic [ADDR_W-1:0]        clr_cnt_q;
  logic signed [CELL_W:0]   sum;
  logic signed [CELL_W-1:0] wdata;

  always_comb begin
    sum = {rdata_q[CELL_W-1], rdata_q} + (CELL_W+1)'(req_i.add_val);
    if (sum > SAT_MAX) begin
      wdata = SAT_MAX[CELL_W-1:0];
    end else if (sum < SAT_MIN) begin
      wdata = SAT_MIN[CELL_W-1:0];
    end else begin
      wdata = sum[CELL_W-1:0];
    end
    if (!req_i.wr_acc) begin
      wdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr[ADDR_W-1:0]] <= wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr[ADDR_W-1:0]];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clr_q;

`ifndef NO_ASSERTIONS
  a_acc_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.wr_en && req_i.wr_acc |->
      $past(req_i.rd_en, 3) && ($past(req_i.rd_addr, 3) == req_i.wr_addr))
    else $error("accumulate write without matching read");
  a_zero_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.wr_en && !req_i.wr_acc |->
      $past(req_i.rd_en) && ($past(req_i.rd_addr) == req_i.wr_addr))
    else $error("clear write without matching read");
  a_quiet_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !req_i.rd_en && !req_i.wr_en)
    else $error("grid access during clearing sweep");
`endif

endmodule

// ===== src/pmecs_ctrl.sv =====
// Sequencer: axis split, B-spline weights and per-cell read-modify-write.
// Depends on pmecs_pkg; drives pmecs_grid and pmecs_div through structs.
module pmecs_ctrl import pmecs_pkg::*; #(
  parameter int SPLINE_ORDER = SPLINE_ORDER_DEF,
  parameter int MAX_GRID_DIM = MAX_GRID_DIM_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     req_type_i,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic signed [POS_W-1:0]  pos_z_i,
  input  logic signed [CHG_W-1:0]  charge_i,
  input  logic [IDX_W-1:0]         read_index_i,
  input  logic [GSZ_W-1:0]         grid_size_x_i,
  input  logic [GSZ_W-1:0]         grid_size_y_i,
  input  logic [GSZ_W-1:0]         grid_size_z_i,
  input  logic [INV_W-1:0]         inv_box_x_i,
  input  logic [INV_W-1:0]         inv_box_y_i,
  input  logic [INV_W-1:0]         inv_box_z_i,
  output logic                     done_o,
  output logic signed [CELL_W-1:0] cell_value_o,
  output logic [IDX_W-1:0]         cell_number_o,
  output grid_req_t                grid_req_o,
  input  logic signed [CELL_W-1:0] grid_rdata_i,
  input  logic                     grid_clearing_i,
  output div_req_t                 div_req_o,
  input  div_rsp_t                 div_rsp_i
);

  localparam int DEPTH = MAX_GRID_DIM * MAX_GRID_DIM * MAX_GRID_DIM;
  localparam int CW    = $clog2(MAX_GRID_DIM);
  localparam int KW    = CW + 1;
  localparam int JW    = (SPLINE_ORDER > 2) ? $clog2(SPLINE_ORDER) : 1;
  localparam int NW    = $clog2(SPLINE_ORDER + 1);
  localparam logic [WT_W-1:0] W_ONE = WT_W'(1) << FRAC_W;

  ctrl_state_e state_q, state_d;

  logic signed [POS_W-1:0] pos_q [3];
  logic signed [CHG_W-1:0] q_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    idx_ok_q;
  logic [GAW-1:0]          addr_q;
  logic [2*KW-1:0]         kxy_q;
  logic [1:0]              axis_q;
  logic [NW-1:0]           n_q;
  logic [JW-1:0]           j_q, jx_q, jy_q, jz_q;
  logic [CW-1:0]           sc_q [3];
  logic [CW-1:0]           cx_q, cy_q, cz_q;
  logic [WT_W-1:0]         wt_q [3][SPLINE_ORDER];
  logic [FRAC_W-1:0]       frac_q;
  logic signed [63:0]      prod_q;
  logic signed [55:0]      u_q;
  logic [63:0]             pa_q, pb_q;
  logic [61:0]             p12_q, p123_q;
  logic signed [63:0]      pq_q;
  logic                    done_q;
  logic signed [CELL_W-1:0] cell_value_q;
  logic [IDX_W-1:0]        cell_number_q;

  logic [KW-1:0]           kx, ky, kz, k_sel;
  logic signed [POS_W-1:0] pos_sel;
  logic [INV_W-1:0]        inv_sel;
  logic                    accept, small_q, idx_ok_in, last_cell, to_cells;
  logic signed [64:0]      prod_full;
  logic signed [55:0]      u_full;
  logic signed [31:0]      wrap_num;
  logic [33:0]             a_fac, b_fac;
  logic [64:0]             pa_full, pb_full;
  logic                    use_a, use_b;
  logic [63:0]             bs_sum;
  logic [61:0]             p12_full, p123_full;
  logic [61:0]             r12, r123;
  logic signed [63:0]      pq_full, pq_rnd;
  logic [19:0]             addr_full;

  function automatic logic [KW-1:0] clamp_dim(input logic [GSZ_W-1:0] g);
    logic [7:0] g8;
    g8 = 8'(g);
    if (g8 == 8'd0) begin
      return KW'(1);
    end else if (g8 > 8'(MAX_GRID_DIM)) begin
      return KW'(MAX_GRID_DIM);
    end
    return KW'(g8);
  endfunction

  function automatic logic [CW-1:0] step_wrap(input logic [CW-1:0] c, input logic [KW-1:0] k);
    logic [KW-1:0] nx;
    nx = KW'(c) + KW'(1);
    return (nx == k) ? '0 : CW'(nx);
  endfunction

  assign kx = clamp_dim(grid_size_x_i);
  assign ky = clamp_dim(grid_size_y_i);
  assign kz = clamp_dim(grid_size_z_i);

  always_comb begin
    case (axis_q)
      2'd0: begin
        pos_sel = pos_q[0];
        inv_sel = inv_box_x_i;
        k_sel   = kx;
      end
      2'd1: begin
        pos_sel = pos_q[1];
        inv_sel = inv_box_y_i;
        k_sel   = ky;
      end
      default: begin
        pos_sel = pos_q[2];
        inv_sel = inv_box_z_i;
        k_sel   = kz;
      end
    endcase
  end

  assign small_q   = (charge_i > -32'sd27) && (charge_i < 32'sd27);
  assign idx_ok_in = 32'(read_index_i) < 32'(DEPTH);
  assign accept    = start_i && !busy_o;
  assign last_cell = (jx_q == '0) && (jy_q == '0) && (jz_q == '0);

  assign prod_full = pos_sel * $signed({1'b0, inv_sel});
  assign u_full    = $signed(prod_q[63:16]) * $signed({1'b0, 7'(k_sel)});
  assign wrap_num  = 32'($signed(u_q[55:32])) - 32'(SPLINE_ORDER - 1)
                     + (32'(k_sel) << BASE_OFF);

  assign use_a   = (5'(j_q) + 5'd2) <= 5'(n_q);
  assign use_b   = (j_q != '0);
  assign a_fac   = (34'(j_q) << FRAC_W) + 34'(frac_q);
  assign b_fac   = (34'(n_q - NW'(j_q)) << FRAC_W) - 34'(frac_q);
  assign pa_full = use_a ? a_fac * wt_q[axis_q][j_q] : '0;
  assign pb_full = use_b ? b_fac * wt_q[axis_q][JW'(j_q - 1'b1)] : '0;
  assign bs_sum  = pa_q + pb_q + (64'(n_q - 1'b1) << (FRAC_W - 1));

  assign p12_full  = 62'(wt_q[0][jx_q] * wt_q[1][jy_q]);
  assign r12       = p12_q + (62'(1) << (FRAC_W - 1));
  assign p123_full = 62'(r12[60:30] * wt_q[2][jz_q]);
  assign r123      = p123_q + (62'(1) << (FRAC_W - 1));
  assign pq_full   = q_q * $signed({1'b0, r123[60:30]});
  assign pq_rnd    = pq_q + (64'sd1 <<< (FRAC_W - 1));
  assign addr_full = 20'(cx_q) + 20'(cy_q) * 20'(kx) + 20'(cz_q) * 20'(kxy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    busy_o     = 1'b1;
    to_cells   = 1'b0;
    grid_req_o = '0;
    div_req_o  = '0;
    grid_req_o.wr_addr = addr_q;
    grid_req_o.add_val = pq_rnd[63:30];
    case (state_q)
      ST_IDLE: begin
        busy_o = grid_clearing_i;
        grid_req_o.rd_addr = GAW'(read_index_i);
        if (start_i && !grid_clearing_i) begin
          if (req_type_i) begin
            grid_req_o.rd_en = idx_ok_in;
            state_d = ST_RD;
          end else if (!small_q) begin
            state_d = ST_SPL_MUL;
          end
        end
      end
      ST_RD: begin
        grid_req_o.wr_en = idx_ok_q;
        state_d = ST_IDLE;
      end
      ST_SPL_MUL:   state_d = ST_SPL_SCALE;
      ST_SPL_SCALE: state_d = ST_SPL_WRAP;
      ST_SPL_WRAP: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = DIV_NUM_W'(unsigned'(wrap_num));
        div_req_o.den   = DIV_DEN_W'(k_sel);
        state_d = ST_SPL_WAIT;
      end
      ST_SPL_WAIT: begin
        if (div_rsp_i.done) begin
          if (SPLINE_ORDER > 2) begin
            state_d = ST_BS_MUL;
          end else begin
            to_cells = (axis_q == 2'd2);
            state_d  = to_cells ? ST_CELL_A : ST_SPL_MUL;
          end
        end
      end
      ST_BS_MUL: state_d = ST_BS_SUM;
      ST_BS_SUM: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = DIV_NUM_W'(bs_sum[63:30]);
        div_req_o.den   = DIV_DEN_W'(n_q - 1'b1);
        state_d = ST_BS_WAIT;
      end
      ST_BS_WAIT: begin
        if (div_rsp_i.done) begin
          if (j_q == '0 && n_q == NW'(SPLINE_ORDER)) begin
            to_cells = (axis_q == 2'd2);
            state_d  = to_cells ? ST_CELL_A : ST_SPL_MUL;
          end else begin
            state_d = ST_BS_MUL;
          end
        end
      end
      ST_CELL_A: begin
        grid_req_o.rd_en   = 1'b1;
        grid_req_o.rd_addr = GAW'(addr_full);
        state_d = ST_CELL_B;
      end
      ST_CELL_B: state_d = ST_CELL_C;
      ST_CELL_C: state_d = ST_CELL_D;
      ST_CELL_D: begin
        grid_req_o.wr_en  = 1'b1;
        grid_req_o.wr_acc = 1'b1;
        state_d = last_cell ? ST_IDLE : ST_CELL_A;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= '0;
      n_q    <= '0;
      j_q    <= '0;
      jx_q   <= '0;
      jy_q   <= '0;
      jz_q   <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == ST_RD);
      if (state_q == ST_IDLE && accept) begin
        axis_q <= '0;
      end
      if ((state_q == ST_SPL_WAIT || state_q == ST_BS_WAIT) && div_rsp_i.done) begin
        if (state_q == ST_SPL_WAIT && SPLINE_ORDER > 2) begin
          n_q <= NW'(3);
          j_q <= JW'(2);
        end else if (state_q == ST_BS_WAIT && !(j_q == '0 && n_q == NW'(SPLINE_ORDER))) begin
          if (j_q == '0) begin
            n_q <= n_q + 1'b1;
            j_q <= JW'(n_q);
          end else begin
            j_q <= j_q - 1'b1;
          end
        end else if (to_cells) begin
          jx_q <= JW'(SPLINE_ORDER - 1);
          jy_q <= JW'(SPLINE_ORDER - 1);
          jz_q <= JW'(SPLINE_ORDER - 1);
        end else begin
          axis_q <= axis_q + 1'b1;
        end
      end
      if (state_q == ST_CELL_D) begin
        if (jx_q != '0) begin
          jx_q <= jx_q - 1'b1;
        end else begin
          jx_q <= JW'(SPLINE_ORDER - 1);
          if (jy_q != '0) begin
            jy_q <= jy_q - 1'b1;
          end else begin
            jy_q <= JW'(SPLINE_ORDER - 1);
            jz_q <= jz_q - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        pos_q[0] <= pos_x_i;
        pos_q[1] <= pos_y_i;
        pos_q[2] <= pos_z_i;
        q_q      <= charge_i;
        idx_q    <= read_index_i;
        idx_ok_q <= idx_ok_in;
        addr_q   <= GAW'(read_index_i);
        kxy_q    <= kx * ky;
      end
      ST_RD: begin
        cell_value_q  <= idx_ok_q ? grid_rdata_i : '0;
        cell_number_q <= idx_q;
      end
      ST_SPL_MUL:   prod_q <= prod_full[63:0];
      ST_SPL_SCALE: u_q    <= u_full;
      ST_SPL_WRAP: begin
        frac_q          <= u_q[31:2];
        wt_q[axis_q][0] <= WT_W'(u_q[31:2]);
        wt_q[axis_q][1] <= W_ONE - WT_W'(u_q[31:2]);
      end
      ST_SPL_WAIT: begin
        if (div_rsp_i.done) begin
          sc_q[axis_q] <= CW'(div_rsp_i.rem);
          if (to_cells) begin
            cx_q <= sc_q[0];
            cy_q <= sc_q[1];
            cz_q <= CW'(div_rsp_i.rem);
          end
        end
      end
      ST_BS_MUL: begin
        pa_q <= pa_full[63:0];
        pb_q <= pb_full[63:0];
      end
      ST_BS_WAIT: begin
        if (div_rsp_i.done) begin
          wt_q[axis_q][j_q] <= WT_W'(div_rsp_i.quo);
          if (to_cells) begin
            cx_q <= sc_q[0];
            cy_q <= sc_q[1];
            cz_q <= sc_q[2];
          end
        end
      end
      ST_CELL_A: begin
        p12_q  <= p12_full;
        addr_q <= GAW'(addr_full);
      end
      ST_CELL_B: p123_q <= p123_full;
      ST_CELL_C: pq_q   <= pq_full;
      ST_CELL_D: begin
        if (jx_q != '0) begin
          cx_q <= step_wrap(cx_q, kx);
        end else begin
          cx_q <= sc_q[0];
          if (jy_q != '0) begin
            cy_q <= step_wrap(cy_q, ky);
          end else begin
            cy_q <= sc_q[1];
            cz_q <= step_wrap(cz_q, kz);
          end
        end
      end
      default: ;
    endcase
  end

  assign done_o        = done_q;
  assign cell_value_o  = cell_value_q;
  assign cell_number_o = cell_number_q;

`ifndef NO_ASSERTIONS
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_type_i |-> ##2 done_o)
    else $error("read request did not answer in two cycles");
  a_deposit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !req_type_i && !small_q |=> busy_o && !done_o)
    else $error("deposit did not start the sequencer");
`endif

endmodule

// ===== src/pme_charge_spreading.sv =====
// Top level of the PME charge spreading block: APB registers and instances.
// Depends on pmecs_pkg, pmecs_div, pmecs_grid and pmecs_ctrl.
//
// Usage: raise start with a word on the request ports; it is taken at an edge
// where start is high and busy is low. A deposit (req_type 0) spreads the
// charge into SPLINE_ORDER^3 grid cells and returns nothing. A read
// (req_type 1) returns the cell at read_index and clears it: cell_value_o
// and cell_number_o are valid for the single cycle in which done_o is high;
// done_o is registered from the ST_RD state that the accepting edge enters;
// the receiver cannot stall it. A read keeps busy high for ST_RD only. A
// deposit keeps busy high through the axis splits and the weights, each of
// which waits on the shared byte divider, and through the read-modify-write
// of each cell on the single grid port. Charges below 27 LSB are dropped
// with no busy time. After reset the grid is cleared by a sweep over all
// MAX_GRID_DIM^3 cells (32768 by default) with busy high; registers load
// their reset values and may be written over APB during the sweep.
module pme_charge_spreading import pmecs_pkg::*; #(
  parameter int SPLINE_ORDER = SPLINE_ORDER_DEF,
  parameter int MAX_GRID_DIM = MAX_GRID_DIM_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,
  input  logic                     start,
  output logic                     busy,
  input  logic                     req_type_i,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic signed [POS_W-1:0]  pos_z_i,
  input  logic signed [CHG_W-1:0]  charge_i,
  input  logic [IDX_W-1:0]         read_index_i,
  output logic                     done_o,
  output logic signed [CELL_W-1:0] cell_value_o,
  output logic [IDX_W-1:0]         cell_number_o
);

  logic [GSZ_W-1:0] gsx_q, gsy_q, gsz_q;
  logic [INV_W-1:0] ibx_q, iby_q, ibz_q;
  logic             wr_en;
  reg_idx_e         reg_sel;

  grid_req_t                grid_req;
  logic signed [CELL_W-1:0] grid_rdata;
  logic                     grid_clearing;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gsx_q <= GSZ_W'(32);
      gsy_q <= GSZ_W'(32);
      gsz_q <= GSZ_W'(32);
      ibx_q <= INV_W'(134217728);
      iby_q <= INV_W'(134217728);
      ibz_q <= INV_W'(134217728);
    end else if (wr_en) begin
      case (reg_sel)
        REG_GRID_X: gsx_q <= pwdata[GSZ_W-1:0];
        REG_GRID_Y: gsy_q <= pwdata[GSZ_W-1:0];
        REG_GRID_Z: gsz_q <= pwdata[GSZ_W-1:0];
        REG_INV_X:  ibx_q <= pwdata;
        REG_INV_Y:  iby_q <= pwdata;
        REG_INV_Z:  ibz_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GRID_X: prdata = PDATA_W'(gsx_q);
      REG_GRID_Y: prdata = PDATA_W'(gsy_q);
      REG_GRID_Z: prdata = PDATA_W'(gsz_q);
      REG_INV_X:  prdata = ibx_q;
      REG_INV_Y:  prdata = iby_q;
      REG_INV_Z:  prdata = ibz_q;
      default:    prdata = '0;
    endcase
  end

  pmecs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pmecs_grid #(
    .MAX_GRID_DIM (MAX_GRID_DIM)
  ) u_grid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (grid_req),
    .rdata_o    (grid_rdata),
    .clearing_o (grid_clearing)
  );

  pmecs_ctrl #(
    .SPLINE_ORDER (SPLINE_ORDER),
    .MAX_GRID_DIM (MAX_GRID_DIM)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .req_type_i      (req_type_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .charge_i        (charge_i),
    .read_index_i    (read_index_i),
    .grid_size_x_i   (gsx_q),
    .grid_size_y_i   (gsy_q),
    .grid_size_z_i   (gsz_q),
    .inv_box_x_i     (ibx_q),
    .inv_box_y_i     (iby_q),
    .inv_box_z_i     (ibz_q),
    .done_o          (done_o),
    .cell_value_o    (cell_value_o),
    .cell_number_o   (cell_number_o),
    .grid_req_o      (grid_req),
    .grid_rdata_i    (grid_rdata),
    .grid_clearing_i (grid_clearing),
    .div_req_o       (div_req),
    .div_rsp_i       (div_rsp)
  );

endmodule

// ===== verif/tb_pme_charge_spreading.sv =====
// Self-checking testbench for pme_charge_spreading: predicts every grid read
// from its own charge grid model and compares it with done_o results.
// Depends on pmecs_pkg and the pme_charge_spreading RTL.
module tb_pme_charge_spreading;
  import pmecs_pkg::*;

  localparam int ORDER     = SPLINE_ORDER_DEF;
  localparam int DIM       = MAX_GRID_DIM_DEF;
  localparam int DEPTH     = DIM * DIM * DIM;
  localparam longint WONE  = 64'd1 << 30;
  localparam longint CMAX  = 64'd140737488355327;
  localparam longint CMIN  = -CMAX - 1;
  localparam int CYC_LIMIT = 3000000;

  typedef longint unsigned weights_t [ORDER];

  typedef struct {
    logic signed [CELL_W-1:0] value;
    logic [IDX_W-1:0]         number;
  } cell_word_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic start, busy, done_o;
  logic req_type_i;
  logic signed [POS_W-1:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [CHG_W-1:0] charge_i;
  logic [IDX_W-1:0] read_index_i;
  logic signed [CELL_W-1:0] cell_value_o;
  logic [IDX_W-1:0] cell_number_o;

  longint     grid_cells [DEPTH];
  logic [GSZ_W-1:0] size_reg [3];
  logic [INV_W-1:0] inv_reg [3];
  cell_word_t pending_reads [$];
  int mismatches;
  int cycles;
  bit idle_on;

  pme_charge_spreading DUT (.*);

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(string what, longint exp_v, longint act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, act_v, $realtime);
  endtask

  always @(posedge clk_i) begin
    cell_word_t e;
    if (rst_ni && done_o) begin
      if (pending_reads.size() == 0) begin
        flag_mismatch("unexpected word, cell", -1, cell_number_o);
      end else begin
        e = pending_reads.pop_front();
        if (cell_value_o !== e.value) flag_mismatch("cell_value", e.value, cell_value_o);
        if (cell_number_o !== e.number) flag_mismatch("cell_number", e.number, cell_number_o);
      end
    end
  end

  function automatic longint dim_of(int a);
    if (size_reg[a] == 0) return 1;
    if (size_reg[a] > DIM) return DIM;
    return longint'(size_reg[a]);
  endfunction

  function automatic longint rnd30(longint x);
    return (x + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void split_axis(input logic [31:0] pos, input logic [31:0] inv,
                                     input longint k, output longint base,
                                     output longint unsigned frac);
    longint p, s, u;
    p = longint'($signed(pos)) * longint'({32'd0, inv});
    s = p >>> 16;
    u = s * k;
    base = u >>> 32;
    frac = longint'(u[31:2]);
  endfunction

  function automatic weights_t spline_weights(longint unsigned w);
    weights_t wt;
    longint unsigned a, b, d;
    wt[0] = w;
    wt[1] = WONE - w;
    for (int n = 3; n <= ORDER; n++) begin
      d = longint'(n - 1) << 30;
      for (int j = n - 1; j >= 0; j--) begin
        a = 0;
        b = 0;
        if (j <= n - 2) a = (w + longint'(j) * WONE) * wt[j];
        if (j >= 1) b = (longint'(n - j) * WONE - w) * wt[j-1];
        wt[j] = (a + b + d / 2) / d;
      end
    end
    return wt;
  endfunction

  function automatic longint wrap_cell(longint m, longint k);
    longint r;
    r = m % k;
    if (r < 0) r += k;
    return r;
  endfunction

  function automatic void spread_charge(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                        logic [31:0] q32);
    longint q, kx, ky, kz, bx, by, bz, mx, my, mz, idx, w12, w123, add, v;
    longint unsigned fx, fy, fz;
    weights_t wx, wy, wz;
    q = longint'($signed(q32));
    if (q > -CHARGE_SKIP && q < CHARGE_SKIP) return;
    kx = dim_of(0);
    ky = dim_of(1);
    kz = dim_of(2);
    split_axis(px, inv_reg[0], kx, bx, fx);
    split_axis(py, inv_reg[1], ky, by, fy);
    split_axis(pz, inv_reg[2], kz, bz, fz);
    wx = spline_weights(fx);
    wy = spline_weights(fy);
    wz = spline_weights(fz);
    for (int jz = ORDER - 1; jz >= 0; jz--) begin
      mz = wrap_cell(bz - jz, kz);
      for (int jy = ORDER - 1; jy >= 0; jy--) begin
        my = wrap_cell(by - jy, ky);
        for (int jx = ORDER - 1; jx >= 0; jx--) begin
          mx = wrap_cell(bx - jx, kx);
          idx = mx + my * kx + mz * kx * ky;
          w12 = rnd30(longint'(wx[jx] * wy[jy]));
          w123 = rnd30(w12 * longint'(wz[jz]));
          add = rnd30(q * w123);
          v = grid_cells[idx] + add;
          if (v > CMAX) v = CMAX;
          if (v < CMIN) v = CMIN;
          grid_cells[idx] = v;
        end
      end
    end
  endfunction

  task automatic send_word(bit rd, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [31:0] q, logic [IDX_W-1:0] idx);
    cell_word_t e;
    @(negedge clk_i);
    start <= 1'b1;
    req_type_i <= rd;
    pos_x_i <= px;
    pos_y_i <= py;
    pos_z_i <= pz;
    charge_i <= q;
    read_index_i <= idx;
    do @(posedge clk_i); while (busy);
    if (rd) begin
      e.value = grid_cells[idx][CELL_W-1:0];
      e.number = idx;
      grid_cells[idx] = 0;
      pending_reads.push_back(e);
    end else begin
      spread_charge(px, py, pz, q);
    end
  endtask

  task automatic sender_gap();
    int n;
    if (!idle_on || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 17);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_reads.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e r, logic [31:0] v);
    wait_idle();
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PADDR_W'(4 * int'(r));
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (r <= REG_GRID_Z) size_reg[int'(r)] = v[GSZ_W-1:0];
    else inv_reg[int'(r) - 3] = v;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic read_cell(int idx);
    send_word(1'b1, '0, '0, '0, '0, IDX_W'(idx));
  endtask

  task automatic drain_grid(int n);
    for (int i = 0; i < n; i++) read_cell(i);
  endtask

  task automatic test_small_charge();
    write_reg(REG_GRID_X, 4);
    write_reg(REG_GRID_Y, 4);
    write_reg(REG_GRID_Z, 4);
    send_word(1'b0, 32'h0001_8000, 32'h0002_4000, 32'h0003_0000, 32'sd26, '0);
    send_word(1'b0, 32'h0001_8000, 32'h0002_4000, 32'h0003_0000, -32'sd26, '0);
    send_word(1'b0, 32'h0001_8000, 32'h0002_4000, 32'h0003_0000, 32'sd0, '0);
    send_word(1'b0, 32'h0001_8000, 32'h0002_4000, 32'h0003_0000, 32'sd27, '0);
    send_word(1'b0, 32'hFFFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, -32'sd27, '0);
    drain_grid(8);
  endtask

  task automatic test_extremes();
    write_reg(REG_GRID_X, 0);
    write_reg(REG_GRID_Y, 2);
    write_reg(REG_GRID_Z, 63);
    write_reg(REG_INV_X, 32'hFFFF_FFFF);
    write_reg(REG_INV_Y, 32'h0000_0000);
    write_reg(REG_INV_Z, 32'h8000_0001);
    send_word(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    send_word(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    send_word(1'b0, 32'h1234_5678, 32'hFEDC_BA98, 32'h0000_0001, 32'h1000_0000, '0);
    read_cell(0);
    read_cell(1);
    read_cell(32767);
    read_cell(2 * 32 + 1);
    write_reg(REG_GRID_Z, 3);
    read_cell(2 * 31);
    read_cell(5);
  endtask

  task automatic test_wrap_order();
    write_reg(REG_GRID_X, 1);
    write_reg(REG_GRID_Y, 3);
    write_reg(REG_GRID_Z, 32);
    write_reg(REG_INV_X, 32'h0800_0000);
    write_reg(REG_INV_Y, 32'h1000_0000);
    write_reg(REG_INV_Z, 32'h0800_0000);
    send_word(1'b0, 32'hFFFF_8000, 32'h0000_4000, 32'h0001_0000, 32'h2000_0000, '0);
    send_word(1'b0, 32'h0040_0000, 32'hFF00_0000, 32'hFFFF_FFFF, 32'hE000_0000, '0);
    for (int i = 0; i < 8; i++) read_cell(i * 3 + (i % 3));
  endtask

  task automatic test_random_traffic();
    int ncells, n;
    logic [31:0] px, py, pz, q;
    for (int ph = 0; ph < 9; ph++) begin
      idle_on = (ph < 7);
      for (int a = 0; a < 3; a++) begin
        case ($urandom_range(0, 5))
          0: n = $urandom_range(0, 63);
          1: n = 32;
          default: n = $urandom_range(1, 6);
        endcase
        write_reg(reg_idx_e'(a), n);
        case ($urandom_range(0, 3))
          0: write_reg(reg_idx_e'(a + 3), $urandom());
          default: write_reg(reg_idx_e'(a + 3), $urandom_range(32'h0100_0000, 32'h4000_0000));
        endcase
      end
      ncells = int'(dim_of(0) * dim_of(1) * dim_of(2));
      for (int i = 0; i < 180; i++) begin
        sender_gap();
        if ($urandom_range(0, 9) < 4) begin
          if ($urandom_range(0, 3) == 0) begin
            px = $urandom(); py = $urandom(); pz = $urandom();
          end else begin
            px = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
            py = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
            pz = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
          end
          case ($urandom_range(0, 5))
            0: q = $urandom_range(0, 60) - 30;
            1: q = $urandom();
            default: q = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
          endcase
          send_word(1'b0, px, py, pz, q, IDX_W'($urandom()));
        end else begin
          if ($urandom_range(0, 9) < 7) read_cell($urandom_range(0, ncells - 1));
          else read_cell($urandom_range(0, DEPTH - 1));
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0; req_type_i = 1'b0; pos_x_i = '0; pos_y_i = '0; pos_z_i = '0;
    charge_i = '0; read_index_i = '0;
    mismatches = 0;
    cycles = 0;
    idle_on = 1'b1;
    foreach (grid_cells[i]) grid_cells[i] = 0;
    for (int a = 0; a < 3; a++) begin
      size_reg[a] = 6'd32;
      inv_reg[a] = 32'd134217728;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_small_charge();
    test_extremes();
    test_wrap_order();
    test_random_traffic();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pmecs_pkg.sv
src/pmecs_div.sv
src/pmecs_grid.sv
src/pmecs_ctrl.sv
src/pme_charge_spreading.sv
verif/tb_pme_charge_spreading.sv
